// ===== hdl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int REGION_W = 3;
    localparam int BANK_W   = 8;
    localparam int OFFSET_W = 13;
    localparam int COUNT_W  = 16;
    localparam int NUM_PRG  = 3;
    localparam int NUM_CHR  = 8;
    localparam int NUM_NT   = 4;

    // Word kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CPU   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PPU   = 2'd3;

    // Region codes.
    localparam logic [REGION_W-1:0] RGN_NONE = 3'd0;
    localparam logic [REGION_W-1:0] RGN_PRAM = 3'd1;
    localparam logic [REGION_W-1:0] RGN_PROM = 3'd2;
    localparam logic [REGION_W-1:0] RGN_CHR  = 3'd3;
    localparam logic [REGION_W-1:0] RGN_NT   = 3'd4;

    // The window at $E000 always shows the last bank.
    localparam logic [BANK_W-1:0] LAST_BANK = 8'hFF;

    typedef logic [KIND_W-1:0] t_kind;

    typedef struct packed {
        logic [NUM_PRG-1:0][BANK_W-1:0] prg;
        logic [NUM_CHR-1:0][BANK_W-1:0] chr;
        logic [NUM_NT-1:0]              nt;
        logic [COUNT_W-1:0]             irq_count;
        logic                           irq_pending;
    } t_cbm_state;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [BANK_W-1:0]   bank;
        logic [OFFSET_W-1:0] offset;
    } t_cbm_map;

endpackage

// ===== hdl/cbm_if.sv =====
// Handshake interfaces for the request and response words of the mapper.
interface cbm_in_if
    import cbm_pkg::*;
;
    logic              valid;
    logic              ready;
    t_kind             kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output kind, output address, output data, input ready);
    modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

interface cbm_out_if
    import cbm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                irq_asserted;
    logic [REGION_W-1:0] region;
    logic [BANK_W-1:0]   bank;
    logic [OFFSET_W-1:0] offset;

    modport source (output valid, output irq_asserted, output region, output bank,
                    output offset, input ready);
    modport sink   (input valid, input irq_asserted, input region, input bank,
                    input offset, output ready);
endinterface

// ===== hdl/cbm_regs.sv =====
// Mapper register file: CPU write decode, IRQ counter and interrupt flag.
module cbm_regs
    import cbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd,
    input  t_kind             i_kind,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_data,
    output t_cbm_state        o_state,
    output logic              o_irq_next
);

    t_cbm_state r_state;
    t_cbm_state n_state;

    always_comb begin
        logic [COUNT_W-1:0] inc;
        logic [1:0]         idx;
        n_state = r_state;
        inc     = r_state.irq_count + COUNT_W'(1);
        idx     = i_address[12:11];
        case (i_kind)
            KIND_WRITE: begin
                if (i_address[15]) begin
                    if (!i_address[14]) begin
                        // $8000-$BFFF: CHR banks or the counter bytes.
                        if (i_address[10]) begin
                            if (i_address[13]) begin
                                n_state.irq_count[15:8] = i_data;
                                n_state.irq_pending     = 1'b0;
                            end else begin
                                n_state.irq_count[7:0] = i_data;
                            end
                        end else begin
                            n_state.chr[i_address[13:11]] = i_data;
                        end
                    end else if (!i_address[13]) begin
                        if (!i_address[10]) begin
                            n_state.nt[idx] = i_data[0];
                        end
                    end else if (!(i_address[12] && i_address[11]) && !i_address[10]) begin
                        // The top of $F000 belongs to the sound chip, so idx stays below 3.
                        n_state.prg[idx] = i_data;
                    end
                end
            end
            KIND_TICK: begin
                if (r_state.irq_count[15]) begin
                    n_state.irq_count = inc;
                    if (inc == '0) begin
                        n_state.irq_pending = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prg         <= {8'd2, 8'd1, 8'd0};
            r_state.chr         <= {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};
            r_state.nt          <= 4'b1100;
            r_state.irq_count   <= '0;
            r_state.irq_pending <= 1'b0;
        end else if (i_upd) begin
            r_state <= n_state;
        end
    end

    assign o_state    = r_state;
    assign o_irq_next = n_state.irq_pending;

endmodule

// ===== hdl/cbm_map.sv =====
// Address translation for CPU and PPU map queries.
module cbm_map
    import cbm_pkg::*;
(
    input  t_kind             i_kind,
    input  logic [ADDR_W-1:0] i_address,
    input  t_cbm_state        i_state,
    output t_cbm_map          o_map
);

    always_comb begin
        o_map = '0;
        case (i_kind)
            KIND_CPU: begin
                case (i_address[15:13])
                    3'd3: begin
                        o_map.region = RGN_PRAM;
                        o_map.offset = i_address[12:0];
                    end
                    3'd4, 3'd5, 3'd6: begin
                        o_map.region = RGN_PROM;
                        o_map.bank   = i_state.prg[i_address[14:13]];
                        o_map.offset = i_address[12:0];
                    end
                    3'd7: begin
                        o_map.region = RGN_PROM;
                        o_map.bank   = LAST_BANK;
                        o_map.offset = i_address[12:0];
                    end
                    default: begin
                    end
                endcase
            end
            KIND_PPU: begin
                o_map.offset = {3'd0, i_address[9:0]};
                if (!i_address[13]) begin
                    o_map.region = RGN_CHR;
                    o_map.bank   = i_state.chr[i_address[12:10]];
                end else begin
                    o_map.region = RGN_NT;
                    o_map.bank   = {7'd0, i_state.nt[i_address[11:10]]};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/cartridge_bank_mapper_with_irq_top.sv =====
// Top level of the cartridge bank mapper with its cycle-counting interrupt.
// The block takes one request word per clock cycle and returns exactly one response
// word for each, in order. An accepted request is captured in the input register. While
// it waits there, a single combinational pass works on it: it decodes CPU writes into
// the bank, nametable and counter registers, advances the IRQ counter on ticks and
// translates map queries. The response lands in the output register once that register
// is free. The sustained rate is one word per cycle as long as the consumer keeps
// o_rsp.ready high. The output register and the input register form a two-deep pipeline,
// so a new request is still accepted while a finished response waits to be taken, as
// long as the input register is empty. Map queries see the register state left by all
// earlier words, and irq_asserted reports the interrupt line after the word's own effect.
module cartridge_bank_mapper_with_irq_top
    import cbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbm_in_if.sink    i_req,
    cbm_out_if.source o_rsp
);

    // Input register.
    logic              r_in_valid;
    t_kind             r_in_kind;
    logic [ADDR_W-1:0] r_in_address;
    logic [DATA_W-1:0] r_in_data;

    // Output register.
    logic     r_out_valid;
    logic     r_out_irq;
    t_cbm_map r_out_map;

    t_cbm_state state;
    t_cbm_map   map;
    logic       irq_next;
    logic       advance;

    // The word in the input register moves on when the output register is free.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_kind    <= i_req.kind;
            r_in_address <= i_req.address;
            r_in_data    <= i_req.data;
        end
    end

    // Register updates happen exactly once per word, when it moves to the output.
    cbm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (advance),
        .i_kind     (r_in_kind),
        .i_address  (r_in_address),
        .i_data     (r_in_data),
        .o_state    (state),
        .o_irq_next (irq_next)
    );

    // Writes never produce a map answer, so the state before the update is correct here.
    cbm_map u_map (
        .i_kind    (r_in_kind),
        .i_address (r_in_address),
        .i_state   (state),
        .o_map     (map)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_irq <= irq_next;
            r_out_map <= map;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.irq_asserted = r_out_irq;
    assign o_rsp.region       = r_out_map.region;
    assign o_rsp.bank         = r_out_map.bank;
    assign o_rsp.offset       = r_out_map.offset;

`ifndef ASSERT_OFF
    // A counter high-byte write acknowledges the interrupt in the same response.
    a_ack_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_kind == KIND_WRITE && r_in_address[15:13] == 3'b101
         && r_in_address[10]) |=> !o_rsp.irq_asserted)
        else $error("interrupt not acknowledged by counter high-byte write");

    // The interrupt flag is only ever raised by a tick.
    a_irq_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(state.irq_pending) |-> $past(advance && r_in_kind == KIND_TICK))
        else $error("interrupt raised by something other than a tick");

    // A tick leaves the counter alone while its top bit is clear.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_kind == KIND_TICK && !state.irq_count[15])
        |=> $stable(state.irq_count))
        else $error("counter advanced while below its counting range");

    // Register state only changes when a word moves through.
    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(state))
        else $error("register state changed without a word");
`endif

endmodule
